>>> hw/rtl/cdcs_pkg.sv
package cdcs_pkg;

    // Sizing
    localparam int CHANNELS   = 64;
    localparam int MAX_TAPS   = 8;
    localparam int CH_W       = 6;
    localparam int TAP_W      = 3;
    localparam int SAMP_W     = 16;
    localparam int CIU_W      = 7;
    localparam int TIU_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int HIST_LEN   = MAX_TAPS - 1;
    localparam int FILL_W     = $clog2(MAX_TAPS);
    localparam int KCNT_W     = $clog2(MAX_TAPS + 1);
    localparam int DSEL_W     = $clog2(MAX_TAPS);
    localparam int WADDR_W    = CH_W + TAP_W;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = 2 * SAMP_W;
    localparam int SIG_W      = 16;
    localparam int SIG_DEPTH  = 256;
    localparam int SIG_AW     = $clog2(SIG_DEPTH);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE     = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [CIU_W-1:0] CIU_RESET = CIU_W'(64);
    localparam logic [TIU_W-1:0] TIU_RESET = TIU_W'(4);

    // Item modes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_WEIGHT = 1'b1;

    // exp(-1/16) in Q0.32
    localparam logic [31:0] EXP_STEP = 32'd4034748382;

    typedef logic signed [SAMP_W-1:0] samp_t;

    typedef struct packed {
        logic              mode;
        logic [CH_W-1:0]   channel;
        logic [TAP_W-1:0]  tap;
        samp_t             value;
        logic              seq_start;
    } in_item_t;

    typedef struct packed {
        samp_t             activation;
        logic [CH_W-1:0]   channel_out;
    } out_item_t;

    typedef struct packed {
        logic [FILL_W-1:0]    fill;
        samp_t [HIST_LEN-1:0] samp;
    } hist_row_t;

    typedef struct packed {
        logic              latch;
        logic              dec_read;
        logic              wgt_write;
        logic              mac_issue;
        logic [DSEL_W-1:0] mac_d;
        logic              round;
        logic              look;
        logic              prod;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic              drop;
        logic              is_weight;
        logic [KCNT_W-1:0] k_eff;
        logic              rd_pending;
        logic              out_free;
    } status_t;

    typedef struct packed {
        logic              we;
        logic [SIG_AW-1:0] addr;
        logic [SIG_W-1:0]  data;
    } sig_wr_t;

endpackage

>>> hw/rtl/cdcs_sig_gen.sv
module cdcs_sig_gen (
    input  logic              aclk,
    input  logic              aresetn,
    output cdcs_pkg::sig_wr_t sig_wr,
    output logic              done
);
    import cdcs_pkg::*;

    typedef enum logic [5:0] {
        PH_LOAD_HI = 6'b000001,
        PH_DIV_HI  = 6'b000010,
        PH_LOAD_LO = 6'b000100,
        PH_DIV_LO  = 6'b001000,
        PH_MUL     = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

    localparam int HALF     = SIG_DEPTH / 2;
    localparam int N_W      = $clog2(HALF + 1);
    localparam int E_W      = 33;
    localparam int D_W      = 34;
    localparam int NUM_W    = 49;
    localparam int QUO_BITS = 17;
    localparam int CNT_W    = $clog2(QUO_BITS);
    localparam int MACC_W   = 65;
    localparam int PP_W     = 33;

    phase_t               phase_reg, phase_next;
    logic [N_W-1:0]       n_reg, n_next;
    logic [E_W-1:0]       e_reg, e_next;
    logic [E_W-1:0]       rem_reg, rem_next;
    logic [QUO_BITS-1:0]  nlow_reg, nlow_next;
    logic [QUO_BITS-2:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [2:0]           mcnt_reg, mcnt_next;
    logic [PP_W-1:0]      prod_reg, prod_next;
    logic [1:0]           sh_reg, sh_next;
    logic [MACC_W-1:0]    macc_reg, macc_next;

    logic [D_W-1:0]       d_w;
    logic [E_W-1:0]       half_d;
    logic [NUM_W-1:0]     num_hi, num_lo, num_sel;
    logic [D_W-1:0]       trial, diff;
    logic                 ge;
    logic [QUO_BITS-1:0]  q_full;
    logic [SIG_W-1:0]     q_cap;
    logic [16:0]          op_a;
    logic [15:0]          op_b;
    logic [PP_W-1:0]      pp;
    logic [MACC_W-1:0]    prod_ext, macc_sum;
    logic                 div_last;

    // Divisor 1 + e^(-n/16) in Q.32 and the two rounded numerators
    assign d_w     = {1'b0, e_reg} + (D_W'(1) << 32);
    assign half_d  = d_w[D_W-1:1];
    assign num_hi  = (NUM_W'(1) << 48) + NUM_W'(half_d);
    assign num_lo  = {e_reg, 16'b0} + NUM_W'(half_d);
    assign num_sel = (phase_reg == PH_LOAD_HI) ? num_hi : num_lo;

    // One quotient bit per cycle
    assign trial    = {rem_reg, nlow_reg[QUO_BITS-1]};
    assign ge       = (trial >= d_w);
    assign diff     = trial - d_w;
    assign q_full   = {quo_reg, ge};
    assign q_cap    = q_full[QUO_BITS-1] ? {SIG_W{1'b1}} : q_full[SIG_W-1:0];
    assign div_last = (cnt_reg == CNT_W'(QUO_BITS - 1));

    // Partial products of e * EXP_STEP, 17x16 each
    assign op_a = mcnt_reg[1] ? e_reg[32:16] : {1'b0, e_reg[15:0]};
    assign op_b = mcnt_reg[0] ? EXP_STEP[31:16] : EXP_STEP[15:0];
    assign pp   = PP_W'(op_a) * PP_W'(op_b);

    always_comb begin
        unique case (sh_reg)
            2'd0:    prod_ext = MACC_W'(prod_reg);
            2'd1:    prod_ext = MACC_W'(prod_reg) << 16;
            default: prod_ext = MACC_W'(prod_reg) << 32;
        endcase
    end
    assign macc_sum = macc_reg + prod_ext;

    // Table write port
    always_comb begin
        sig_wr.we   = div_last && ((phase_reg == PH_DIV_HI) || (phase_reg == PH_DIV_LO));
        sig_wr.data = q_cap;
        if (phase_reg == PH_DIV_HI) begin
            sig_wr.addr = SIG_AW'(HALF) + SIG_AW'(n_reg);
        end else begin
            sig_wr.addr = SIG_AW'(HALF) - SIG_AW'(n_reg);
        end
    end

    assign done = (phase_reg == PH_DONE);

    // Sequence: divide for the upper half, divide for the lower half, step the exponent
    always_comb begin
        phase_next = phase_reg;
        n_next     = n_reg;
        e_next     = e_reg;
        rem_next   = rem_reg;
        nlow_next  = nlow_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        mcnt_next  = mcnt_reg;
        prod_next  = prod_reg;
        sh_next    = sh_reg;
        macc_next  = macc_reg;
        unique case (phase_reg)
            PH_LOAD_HI, PH_LOAD_LO: begin
                rem_next   = E_W'(num_sel[NUM_W-1:QUO_BITS]);
                nlow_next  = num_sel[QUO_BITS-1:0];
                quo_next   = '0;
                cnt_next   = '0;
                phase_next = (phase_reg == PH_LOAD_HI) ? PH_DIV_HI : PH_DIV_LO;
            end
            PH_DIV_HI, PH_DIV_LO: begin
                rem_next  = ge ? diff[E_W-1:0] : trial[E_W-1:0];
                nlow_next = {nlow_reg[QUO_BITS-2:0], 1'b0};
                quo_next  = q_full[QUO_BITS-2:0];
                cnt_next  = cnt_reg + 1'b1;
                mcnt_next = '0;
                if (div_last) begin
                    if (phase_reg == PH_DIV_HI) begin
                        phase_next = (n_reg == '0) ? PH_MUL : PH_LOAD_LO;
                    end else begin
                        phase_next = (n_reg == N_W'(HALF)) ? PH_DONE : PH_MUL;
                    end
                end
            end
            PH_MUL: begin
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 3'd0) begin
                    macc_next = MACC_W'(1) << 31;
                end else begin
                    macc_next = macc_sum;
                end
                if (mcnt_reg != 3'd4) begin
                    prod_next = pp;
                    sh_next   = 2'({1'b0, mcnt_reg[1]} + {1'b0, mcnt_reg[0]});
                end else begin
                    e_next     = macc_sum[MACC_W-1:32];
                    n_next     = n_reg + 1'b1;
                    mcnt_next  = '0;
                    phase_next = (n_reg + 1'b1 == N_W'(HALF)) ? PH_LOAD_LO : PH_LOAD_HI;
                end
            end
            PH_DONE: begin
                phase_next = PH_DONE;
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LOAD_HI;
            n_reg     <= '0;
            e_reg     <= E_W'(1) << 32;
            cnt_reg   <= '0;
            mcnt_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            n_reg     <= n_next;
            e_reg     <= e_next;
            cnt_reg   <= cnt_next;
            mcnt_reg  <= mcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        nlow_reg <= nlow_next;
        quo_reg  <= quo_next;
        prod_reg <= prod_next;
        sh_reg   <= sh_next;
        macc_reg <= macc_next;
    end

endmodule

>>> hw/rtl/cdcs_ctrl.sv
module cdcs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              init_done,
    input  logic              s_valid,
    output logic              s_ready,
    input  cdcs_pkg::status_t status,
    output cdcs_pkg::cmd_t    cmd
);
    import cdcs_pkg::*;

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DECODE = 9'b000000100,
        S_MAC    = 9'b000001000,
        S_DRAIN  = 9'b000010000,
        S_ROUND  = 9'b000100000,
        S_LOOK   = 9'b001000000,
        S_PROD   = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [KCNT_W-1:0] d_reg, d_next;

    assign s_ready = (state_reg == S_IDLE);

    // Sequence one item through decode; samples go on through the tap loop, rounding, lookup and output
    always_comb begin
        state_next = state_reg;
        d_next     = d_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT: begin
                if (init_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (status.drop) begin
                    state_next = S_IDLE;
                end else if (status.is_weight) begin
                    cmd.wgt_write = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    cmd.dec_read  = 1'b1;
                    cmd.mac_issue = 1'b1;
                    cmd.mac_d     = '0;
                    d_next        = KCNT_W'(1);
                    state_next    = (status.k_eff == KCNT_W'(1)) ? S_DRAIN : S_MAC;
                end
            end
            S_MAC: begin
                cmd.mac_issue = 1'b1;
                cmd.mac_d     = d_reg[DSEL_W-1:0];
                d_next        = d_reg + 1'b1;
                if (d_reg == status.k_eff - 1'b1) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!status.rd_pending) begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND: begin
                cmd.round  = 1'b1;
                state_next = S_LOOK;
            end
            S_LOOK: begin
                cmd.look   = 1'b1;
                state_next = S_PROD;
            end
            S_PROD: begin
                cmd.prod   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            d_reg     <= '0;
        end else begin
            state_reg <= state_next;
            d_reg     <= d_next;
        end
    end

endmodule

>>> hw/rtl/cdcs_datapath.sv
module cdcs_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cdcs_pkg::cmd_t                      cmd,
    output cdcs_pkg::status_t                   status,
    input  cdcs_pkg::in_item_t                  s_data,
    input  logic                                cfg_valid,
    input  logic [cdcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cdcs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  cdcs_pkg::sig_wr_t                   sig_wr,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cdcs_pkg::out_item_t                 m_data
);
    import cdcs_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_HI  = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] ACC_LO  = -ACC_W'(32768);
    localparam logic signed [17:0]      FIN_HI  = 18'sd32767;
    localparam logic signed [17:0]      FIN_LO  = -18'sd32768;

    // Stores
    samp_t            weight_mem [CHANNELS*MAX_TAPS];
    hist_row_t        hist_mem   [CHANNELS];
    logic [SIG_W-1:0] sig_mem    [SIG_DEPTH];

    // Registers
    in_item_t           item_reg;
    logic [CIU_W-1:0]   ciu_reg;
    logic [TIU_W-1:0]   tiu_reg;
    logic [CHANNELS-1:0] hvalid_reg;
    samp_t              w_rd_reg;
    hist_row_t          h_rd_reg;
    logic               hv_rd_reg;
    logic               rd_valid_reg;
    logic [DSEL_W-1:0]  rd_d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic               mul_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    samp_t              s_reg;
    logic [SIG_W-1:0]   sig_rd_reg;
    logic signed [SAMP_W+SIG_W:0] fin_reg;
    out_item_t          out_reg;
    logic               m_valid_reg;

    // Comb
    logic [KCNT_W-1:0]  k_eff;
    logic [KCNT_W-1:0]  tap_sel;
    logic [WADDR_W-1:0] w_raddr;
    logic [FILL_W-1:0]  fill_eff;
    samp_t              x_sel;
    logic signed [ACC_W-1:0] acc_rnd, acc_sh;
    samp_t              s_sat;
    logic signed [17:0] t_idx;
    logic [SIG_AW-1:0]  sig_idx;
    logic signed [SAMP_W+SIG_W+1:0] fin_rnd;
    logic signed [17:0] fin_sh;
    samp_t              a_sat;
    hist_row_t          h_new;

    // Effective kernel length
    always_comb begin
        if (tiu_reg == '0) begin
            k_eff = KCNT_W'(1);
        end else if (int'(tiu_reg) > MAX_TAPS) begin
            k_eff = KCNT_W'(MAX_TAPS);
        end else begin
            k_eff = KCNT_W'(tiu_reg);
        end
    end

    always_comb begin
        status.drop       = ({1'b0, item_reg.channel} >= ciu_reg)
                            || (int'(item_reg.channel) >= CHANNELS);
        status.is_weight  = (item_reg.mode == MODE_WEIGHT);
        status.k_eff      = k_eff;
        status.rd_pending = rd_valid_reg;
        status.out_free   = !m_valid_reg || m_ready;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ciu_reg <= CIU_RESET;
            tiu_reg <= TIU_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CHANNELS_IN_USE: ciu_reg <= cfg_data[CIU_W-1:0];
                REG_TAPS_IN_USE:     tiu_reg <= cfg_data[TIU_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_reg <= s_data;
        end
    end

    // Weight store: one tap written per load, one tap read per loop step
    assign tap_sel = k_eff - 1'b1 - KCNT_W'(cmd.mac_d);
    assign w_raddr = {item_reg.channel, tap_sel[TAP_W-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.wgt_write && (int'(item_reg.tap) < MAX_TAPS)) begin
            weight_mem[{item_reg.channel, item_reg.tap}] <= item_reg.value;
        end
        if (cmd.mac_issue) begin
            w_rd_reg <= weight_mem[w_raddr];
        end
    end

    // History row: read at decode, written back shifted at rounding
    assign fill_eff = item_reg.seq_start ? '0 : (hv_rd_reg ? h_rd_reg.fill : '0);

    always_comb begin
        h_new = h_rd_reg;
        for (int j = HIST_LEN - 1; j >= 1; j--) begin
            h_new.samp[j] = h_rd_reg.samp[j-1];
        end
        h_new.samp[0] = item_reg.value;
        h_new.fill    = (int'(fill_eff) < HIST_LEN) ? fill_eff + 1'b1 : fill_eff;
    end

    always_ff @(posedge aclk) begin
        if (cmd.dec_read) begin
            h_rd_reg <= hist_mem[item_reg.channel];
        end
        if (cmd.round) begin
            hist_mem[item_reg.channel] <= h_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hvalid_reg <= '0;
        end else if (cmd.round) begin
            hvalid_reg[item_reg.channel] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dec_read) begin
            hv_rd_reg <= hvalid_reg[item_reg.channel];
        end
    end

    // Tap loop: read weight, multiply, accumulate
    always_comb begin
        x_sel = '0;
        if (rd_d_reg == '0) begin
            x_sel = item_reg.value;
        end else if (rd_d_reg <= fill_eff) begin
            x_sel = h_rd_reg.samp[rd_d_reg - 1'b1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= cmd.mac_issue;
            mul_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mac_issue) begin
            rd_d_reg <= cmd.mac_d;
        end
        if (rd_valid_reg) begin
            prod_reg <= PROD_W'(w_rd_reg) * PROD_W'(x_sel);
        end
        if (cmd.dec_read) begin
            acc_reg <= '0;
        end else if (mul_valid_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Round the sum to Q8.8 and saturate
    assign acc_rnd = acc_reg + ACC_W'(1 << 13);
    assign acc_sh  = acc_rnd >>> 14;

    always_comb begin
        if (acc_sh > ACC_HI) begin
            s_sat = 16'sh7FFF;
        end else if (acc_sh < ACC_LO) begin
            s_sat = 16'sh8000;
        end else begin
            s_sat = acc_sh[SAMP_W-1:0];
        end
    end

    // Sigmoid table index, clamped to the table range
    assign t_idx = 18'(s_reg) + 18'sd2048;

    always_comb begin
        if (t_idx < 0) begin
            sig_idx = '0;
        end else if (t_idx[16:4] > 13'(SIG_DEPTH - 1)) begin
            sig_idx = SIG_AW'(SIG_DEPTH - 1);
        end else begin
            sig_idx = t_idx[SIG_AW+3:4];
        end
    end

    always_ff @(posedge aclk) begin
        if (sig_wr.we) begin
            sig_mem[sig_wr.addr] <= sig_wr.data;
        end
        if (cmd.look) begin
            sig_rd_reg <= sig_mem[sig_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.round) begin
            s_reg <= s_sat;
        end
        if (cmd.prod) begin
            fin_reg <= (SAMP_W+SIG_W+1)'(s_reg)
                       * (SAMP_W+SIG_W+1)'($signed({1'b0, sig_rd_reg}));
        end
    end

    // Round the product and saturate
    assign fin_rnd = (SAMP_W+SIG_W+2)'(fin_reg) + (SAMP_W+SIG_W+2)'(1 << 15);
    assign fin_sh  = 18'(fin_rnd >>> 16);

    always_comb begin
        if (fin_sh > FIN_HI) begin
            a_sat = 16'sh7FFF;
        end else if (fin_sh < FIN_LO) begin
            a_sat = 16'sh8000;
        end else begin
            a_sat = fin_sh[SAMP_W-1:0];
        end
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.activation  <= a_sat;
            out_reg.channel_out <= item_reg.channel;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> hw/rtl/causal_depthwise_conv1d_silu.sv
// A sample passes decode, a tap loop over K taps (K = effective kernel length), drain,
// rounding, lookup, product and output. Weight loads and dropped items end at decode.
// One item in flight; the tap loop shares one multiplier and one weight-memory port.
// Reset: synchronous, active low. After reset the sigmoid table is built by a shared
// divider, during which s_ready stays low; configuration writes are taken throughout.
// History reads as empty after reset; weights are undefined.
module causal_depthwise_conv1d_silu (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cdcs_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cdcs_pkg::out_item_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cdcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdcs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cdcs_pkg::*;

    cmd_t    cmd;
    status_t status;
    sig_wr_t sig_wr;
    logic    init_done;

    // Registers accept a write in every cycle
    assign cfg_ready = 1'b1;

    cdcs_sig_gen u_sig_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sig_wr  (sig_wr),
        .done    (init_done)
    );

    cdcs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_done (init_done),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cdcs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sig_wr    (sig_wr),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> hw/rtl/cdcs_checker.sv
module cdcs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input cdcs_pkg::out_item_t m_data
);
    import cdcs_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // One item in flight: no transfer in the cycle after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    // A new result needs the full pipeline after the input transfer
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid) ##1 !$rose(m_valid)
                               ##1 !$rose(m_valid) ##1 !$rose(m_valid))
        else $error("result appeared too soon after input transfer");

    // Reset empties the output and holds off input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("outputs not quiet after reset");

endmodule

bind causal_depthwise_conv1d_silu cdcs_checker u_checker (.*);

>>> dv/causal_depthwise_conv1d_silu_tb.sv
module causal_depthwise_conv1d_silu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdcs_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_PHASES     = 8;
    localparam longint unsigned EXP_Q32 = 64'd4034748382;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    causal_depthwise_conv1d_silu dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Per phase: channels_in_use, taps_in_use, random items
    int unsigned phase_plan [NUM_PHASES][3] = '{
        '{64, 8, 60}, '{1, 1, 30}, '{13, 0, 40},
        '{127, 15, 60}, '{0, 5, 20}, '{40, 3, 50},
        '{64, 2, 60}, '{64, 8, 60}
    };

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    in_item_t    items_to_send [$];
    out_item_t   expected_acts [$];
    int unsigned items_queued = 0;
    int unsigned items_taken  = 0;
    int unsigned fault_count  = 0;

    // Shadow of the block: registers, sigmoid table, taps, history
    int unsigned act_channels = int'(CIU_RESET);
    int unsigned act_taps     = int'(TIU_RESET);
    int          sig_lut [SIG_DEPTH];
    shortint     tap_w [CHANNELS][MAX_TAPS];
    shortint     hist [CHANNELS][HIST_LEN];
    int          fill_cnt [CHANNELS];
    bit          wgt_written [CHANNELS][MAX_TAPS];

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endfunction

    function automatic int clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    // Effective kernel length: zero acts as one, anything above the maximum clips
    function automatic int kernel_len();
        if (act_taps < 1) return 1;
        if (act_taps > MAX_TAPS) return MAX_TAPS;
        return int'(act_taps);
    endfunction

    function automatic int random_weight();
        if ($urandom_range(1)) return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(16383)) - 8192;
    endfunction

    // Apply one accepted item to the shadow state and queue its activation
    task automatic conv_silu_step(input in_item_t it);
        int        k;
        int        fill;
        int        s;
        int        a;
        int        t;
        int        idx;
        longint    acc;
        shortint   v;
        out_item_t r;
        if (it.channel >= act_channels) return;
        v = it.value;
        if (it.mode == MODE_WEIGHT) begin
            tap_w[it.channel][it.tap] = v;
            return;
        end
        k = kernel_len();
        if (it.seq_start) fill_cnt[it.channel] = 0;
        fill = fill_cnt[it.channel];

        // causal FIR over the valid part of the history
        acc = longint'(tap_w[it.channel][k-1]) * longint'(v);
        for (int d = 1; d < k; d++) begin
            if (d <= fill) begin
                acc += longint'(tap_w[it.channel][k-1-d]) * longint'(hist[it.channel][d-1]);
            end
        end

        // shift the new sample into the history
        for (int j = HIST_LEN - 1; j >= 1; j--) begin
            hist[it.channel][j] = hist[it.channel][j-1];
        end
        hist[it.channel][0] = v;
        if (fill < HIST_LEN) fill_cnt[it.channel] = fill + 1;

        // round to Q8.8, look up sigmoid, scale
        s = clamp16((acc + 64'sd8192) >>> 14);
        t = s + 2048;
        if (t < 0) begin
            idx = 0;
        end else begin
            idx = ((t >> 4) > SIG_DEPTH - 1) ? SIG_DEPTH - 1 : (t >> 4);
        end
        a = clamp16((longint'(s) * longint'(sig_lut[idx]) + 64'sd32768) >>> 16);

        r.activation  = SAMP_W'(a);
        r.channel_out = it.channel;
        expected_acts.push_back(r);
    endtask

    task automatic push_weight(input int unsigned ch, input int unsigned tp, input int val);
        in_item_t it;
        it.mode      = MODE_WEIGHT;
        it.channel   = CH_W'(ch);
        it.tap       = TAP_W'(tp);
        it.value     = SAMP_W'(val);
        it.seq_start = 1'($urandom_range(1));
        items_to_send.push_back(it);
        items_queued++;
        if (ch < act_channels) wgt_written[ch][tp] = 1'b1;
    endtask

    // Load any unwritten tap the current kernel would read before sending the sample
    task automatic push_sample(input int unsigned ch, input int val, input bit start);
        in_item_t it;
        if (ch < act_channels) begin
            for (int tp = 0; tp < kernel_len(); tp++) begin
                if (!wgt_written[ch][tp]) push_weight(ch, tp, random_weight());
            end
        end
        it.mode      = MODE_SAMPLE;
        it.channel   = CH_W'(ch);
        it.tap       = TAP_W'($urandom_range(MAX_TAPS - 1));
        it.value     = SAMP_W'(val);
        it.seq_start = start;
        items_to_send.push_back(it);
        items_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CHANNELS_IN_USE) begin
            act_channels = val & 'h7F;
        end else if (idx == REG_TAPS_IN_USE) begin
            act_taps = val & 'hF;
        end
        @(posedge aclk);
    endtask

    // Wait for every item to transfer and every activation to return, then settle
    task automatic wait_idle();
        while (items_taken != items_queued || expected_acts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                conv_silu_step(s_data);
                items_taken++;
            end
            // load the next transfer once the slot frees up, hold otherwise
            if (!s_valid || s_ready) begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= items_to_send.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_acts.size() == 0) begin
                    note_fault($sformatf("unexpected result: ch %0d activation %0d",
                                         m_data.channel_out, m_data.activation));
                end else begin
                    want = expected_acts.pop_front();
                    if (m_data.activation !== want.activation) begin
                        note_fault($sformatf("ch %0d activation: expected %0d, got %0d",
                                             want.channel_out, want.activation,
                                             m_data.activation));
                    end
                    if (m_data.channel_out !== want.channel_out) begin
                        note_fault($sformatf("channel_out: expected %0d, got %0d",
                                             want.channel_out, m_data.channel_out));
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        longint unsigned e_q32 [129];
        longint unsigned en;
        longint unsigned den;
        longint unsigned num;
        longint unsigned q;
        int unsigned     ch;
        int unsigned     span;
        int              counted;

        // Build the sigmoid table from the exp(-n/16) recurrence
        e_q32[0] = 64'd1 << 32;
        for (int n = 1; n <= 128; n++) begin
            e_q32[n] = (e_q32[n-1] * EXP_Q32 + (64'd1 << 31)) >> 32;
        end
        for (int i = 0; i < SIG_DEPTH; i++) begin
            en  = (i >= 128) ? e_q32[i-128] : e_q32[128-i];
            den = (64'd1 << 32) + en;
            num = (i >= 128) ? (64'd1 << 48) : (en << 16);
            q   = (num + den / 2) / den;
            sig_lut[i] = (q > 65535) ? 65535 : int'(q);
        end

        send_idle_pct = 30;
        recv_idle_pct = 61;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Saturate high then low on channel 0; a new sequence drops the history
        for (int tp = 0; tp < 4; tp++) push_weight(0, tp, 32767);
        push_sample(0, 32767, 1'b1);
        push_sample(0, 32767, 1'b0);
        push_sample(0, 32767, 1'b0);
        push_sample(0, -32768, 1'b1);
        push_sample(0, -32768, 1'b0);
        // Most negative weights on the top channel, small inputs near the knee
        for (int tp = 0; tp < 4; tp++) push_weight(63, tp, -32768);
        push_sample(63, 256, 1'b1);
        push_sample(63, 0, 1'b0);
        push_sample(63, -1, 1'b0);
        // A tap beyond the kernel is stored but never read
        push_weight(5, 7, 12345);
        push_sample(5, 128, 1'b1);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 61;
                recv_idle_pct = 30;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_CHANNELS_IN_USE, phase_plan[p][0]);
            write_reg(REG_TAPS_IN_USE, phase_plan[p][1]);

            // Mostly per-channel sequences on live channels, some weight
            // reloads mid-sequence and some items on unused channels
            span = (act_channels == 0) ? 1 : (act_channels > CHANNELS) ? CHANNELS : act_channels;
            counted = 0;
            while (counted < int'(phase_plan[p][2])) begin
                ch = ($urandom_range(9) < 8) ? $urandom_range(span - 1)
                                             : $urandom_range(CHANNELS - 1);
                if ($urandom_range(99) < 10) begin
                    push_weight(ch, $urandom_range(MAX_TAPS - 1), random_weight());
                end else begin
                    push_sample(ch,
                                ($urandom_range(99) < 35) ? int'($urandom_range(65535)) - 32768
                                                          : int'($urandom_range(2047)) - 1024,
                                $urandom_range(11) == 0);
                end
                if (ch < act_channels || act_channels == 0) counted++;
            end
            wait_idle();
        end

        if (fault_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> causal_depthwise_conv1d_silu.f
hw/rtl/cdcs_pkg.sv
hw/rtl/cdcs_sig_gen.sv
hw/rtl/cdcs_ctrl.sv
hw/rtl/cdcs_datapath.sv
hw/rtl/causal_depthwise_conv1d_silu.sv
hw/rtl/cdcs_checker.sv
dv/causal_depthwise_conv1d_silu_tb.sv
